// ===== rtl/cpualu_pkg.sv =====
package cpualu_pkg;

  // Flag nibble bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // Decimal adjust constants
  localparam logic [7:0] DaaUpperLimit = 8'h99;
  localparam logic [7:0] DaaUpperAdj   = 8'h60;
  localparam logic [7:0] DaaLowerAdj   = 8'h06;
  localparam logic [3:0] DaaLowerLimit = 4'd9;

  typedef enum logic [2:0] {
    MODE_ALU  = 3'd0,
    MODE_SHF  = 3'd1,
    MODE_BIT  = 3'd2,
    MODE_RES  = 3'd3,
    MODE_SET  = 3'd4,
    MODE_MISC = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_ADC = 3'd1,
    ALU_SUB = 3'd2,
    ALU_SBC = 3'd3,
    ALU_AND = 3'd4,
    ALU_XOR = 3'd5,
    ALU_OR  = 3'd6,
    ALU_CP  = 3'd7
  } alu_op_t;

  typedef enum logic [2:0] {
    SHF_RLC  = 3'd0,
    SHF_RRC  = 3'd1,
    SHF_RL   = 3'd2,
    SHF_RR   = 3'd3,
    SHF_SLA  = 3'd4,
    SHF_SRA  = 3'd5,
    SHF_SWAP = 3'd6,
    SHF_SRL  = 3'd7
  } shf_op_t;

  typedef enum logic [2:0] {
    MISC_RLCA = 3'd0,
    MISC_RRCA = 3'd1,
    MISC_RLA  = 3'd2,
    MISC_RRA  = 3'd3,
    MISC_DAA  = 3'd4,
    MISC_CPL  = 3'd5,
    MISC_SCF  = 3'd6,
    MISC_CCF  = 3'd7
  } misc_op_t;

  typedef struct packed {
    logic [3:0] flags_in;
    logic [7:0] operand;
    logic [7:0] acc;
    logic [2:0] sel;
    logic [2:0] mode;
  } in_item_t;

  typedef struct packed {
    logic [3:0] flags_out;
    logic       writes_result;
    logic [7:0] result;
  } out_item_t;

endpackage

// ===== rtl/cpu_8bit_alu_with_flags_top.sv =====
// 8-bit processor ALU with Z/N/H/C flags: add, subtract and logic ops, compare,
// rotates, shifts and swap, bit test/reset/set, and the accumulator ops
// (RLCA, RRCA, RLA, RRA, DAA, CPL, SCF, CCF). One transaction is taken per clock
// while s_tready is high. Each is held in the input register, then the ALU logic
// loads the result register, which offers the result on m_tvalid. With m_tready
// held high the block sustains one operation per cycle; s_tready drops only when
// both the input and result registers hold data the downstream side has not taken.
module cpu_8bit_alu_with_flags_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // acc[7:0], operand[15:8], flags_in[19:16], zero[23:20]
  input  logic [5:0]  s_tuser,  // mode[2:0], sel[5:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // result[7:0], flags_out[11:8], zero[15:12]
  output logic        m_tuser   // writes_result
);

  logic                  in_valid;
  cpualu_pkg::in_item_t  in_item;
  logic                  out_valid;
  cpualu_pkg::out_item_t out_item;
  cpualu_pkg::out_item_t core_res;
  logic                  out_load;

  // Result register frees up when empty or being drained this cycle
  assign out_load = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | ~out_valid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode     <= s_tuser[2:0];
      in_item.sel      <= s_tuser[5:3];
      in_item.acc      <= s_tdata[7:0];
      in_item.operand  <= s_tdata[15:8];
      in_item.flags_in <= s_tdata[19:16];
    end
  end

  cpualu_core u_core (
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_item.flags_out, out_item.result};
  assign m_tuser  = out_item.writes_result;

endmodule

// ===== rtl/cpualu_core.sv =====
module cpualu_core (
  input  cpualu_pkg::in_item_t  item,
  output cpualu_pkg::out_item_t res
);

  // Returns {carry, value} for the rotate and shift group
  function automatic logic [8:0] shift_op(input logic [2:0] s, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] o;
    case (cpualu_pkg::shf_op_t'(s))
      cpualu_pkg::SHF_RLC:  o = {v[7], v[6:0], v[7]};
      cpualu_pkg::SHF_RRC:  o = {v[0], v[0], v[7:1]};
      cpualu_pkg::SHF_RL:   o = {v[7], v[6:0], cin};
      cpualu_pkg::SHF_RR:   o = {v[0], cin, v[7:1]};
      cpualu_pkg::SHF_SLA:  o = {v[7], v[6:0], 1'b0};
      cpualu_pkg::SHF_SRA:  o = {v[0], v[7], v[7:1]};
      cpualu_pkg::SHF_SWAP: o = {1'b0, v[3:0], v[7:4]};
      default:              o = {v[0], 1'b0, v[7:1]};
    endcase
    return o;
  endfunction

  logic [7:0] a;
  logic [7:0] b;
  logic [3:0] f;
  logic       cin;
  logic       add_c;
  logic       sub_c;
  logic [8:0] add_full;
  logic [4:0] add_half;
  logic [8:0] sub_full;
  logic [4:0] sub_half;
  logic [8:0] shf_b;
  logic [8:0] shf_a;
  logic [7:0] bit_mask;
  logic [7:0] daa_r;
  logic       daa_c;

  assign a   = item.acc;
  assign b   = item.operand;
  assign f   = item.flags_in;
  assign cin = f[cpualu_pkg::FlagC];

  assign add_c = (item.sel == cpualu_pkg::ALU_ADC) & cin;
  assign sub_c = (item.sel == cpualu_pkg::ALU_SBC) & cin;

  // Bit 8 / bit 4 give carry out on add and borrow on subtract
  assign add_full = {1'b0, a} + {1'b0, b} + {8'd0, add_c};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_c};
  assign sub_full = {1'b0, a} - {1'b0, b} - {8'd0, sub_c};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_c};

  assign shf_b    = shift_op(item.sel, b, cin);
  assign shf_a    = shift_op(item.sel, a, cin);
  assign bit_mask = 8'd1 << item.sel;

  always_comb begin
    daa_r = a;
    daa_c = cin;
    if (!f[cpualu_pkg::FlagN]) begin
      if (cin || (a > cpualu_pkg::DaaUpperLimit)) begin
        daa_r = daa_r + cpualu_pkg::DaaUpperAdj;
        daa_c = 1'b1;
      end
      if (f[cpualu_pkg::FlagH] || (daa_r[3:0] > cpualu_pkg::DaaLowerLimit)) begin
        daa_r = daa_r + cpualu_pkg::DaaLowerAdj;
      end
    end else begin
      if (cin) begin
        daa_r = daa_r - cpualu_pkg::DaaUpperAdj;
      end
      if (f[cpualu_pkg::FlagH]) begin
        daa_r = daa_r - cpualu_pkg::DaaLowerAdj;
      end
    end
  end

  always_comb begin
    res.result        = a;
    res.writes_result = 1'b1;
    res.flags_out     = f;
    case (cpualu_pkg::mode_t'(item.mode))
      cpualu_pkg::MODE_ALU: begin
        case (cpualu_pkg::alu_op_t'(item.sel))
          cpualu_pkg::ALU_ADD, cpualu_pkg::ALU_ADC: begin
            res.result    = add_full[7:0];
            res.flags_out = {add_full[7:0] == 8'd0, 1'b0, add_half[4], add_full[8]};
          end
          cpualu_pkg::ALU_SUB, cpualu_pkg::ALU_SBC, cpualu_pkg::ALU_CP: begin
            res.result        = sub_full[7:0];
            res.flags_out     = {sub_full[7:0] == 8'd0, 1'b1, sub_half[4], sub_full[8]};
            res.writes_result = (item.sel != cpualu_pkg::ALU_CP);
          end
          cpualu_pkg::ALU_AND: begin
            res.result    = a & b;
            res.flags_out = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
          end
          cpualu_pkg::ALU_XOR: begin
            res.result    = a ^ b;
            res.flags_out = {(a ^ b) == 8'd0, 3'b000};
          end
          default: begin
            res.result    = a | b;
            res.flags_out = {(a | b) == 8'd0, 3'b000};
          end
        endcase
      end
      cpualu_pkg::MODE_SHF: begin
        res.result    = shf_b[7:0];
        res.flags_out = {shf_b[7:0] == 8'd0, 2'b00, shf_b[8]};
      end
      cpualu_pkg::MODE_BIT: begin
        res.result        = b;
        res.writes_result = 1'b0;
        res.flags_out     = {(b & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
      end
      cpualu_pkg::MODE_RES: begin
        res.result = b & ~bit_mask;
      end
      cpualu_pkg::MODE_SET: begin
        res.result = b | bit_mask;
      end
      cpualu_pkg::MODE_MISC: begin
        case (cpualu_pkg::misc_op_t'(item.sel))
          cpualu_pkg::MISC_RLCA, cpualu_pkg::MISC_RRCA,
          cpualu_pkg::MISC_RLA, cpualu_pkg::MISC_RRA: begin
            res.result    = shf_a[7:0];
            res.flags_out = {3'b000, shf_a[8]};
          end
          cpualu_pkg::MISC_DAA: begin
            res.result    = daa_r;
            res.flags_out = {daa_r == 8'd0, f[cpualu_pkg::FlagN], 1'b0, daa_c};
          end
          cpualu_pkg::MISC_CPL: begin
            res.result    = ~a;
            res.flags_out = {f[cpualu_pkg::FlagZ], 1'b1, 1'b1, cin};
          end
          cpualu_pkg::MISC_SCF: begin
            res.flags_out = {f[cpualu_pkg::FlagZ], 2'b00, 1'b1};
          end
          default: begin
            res.flags_out = {f[cpualu_pkg::FlagZ], 2'b00, ~cin};
          end
        endcase
      end
      default: begin
        // Unused modes pass the accumulator and flags through, no write-back
        res.writes_result = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/cpualu_checker.sv =====
module cpualu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // Nothing may be presented in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed or dropped");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:12] == 4'd0))
    else $error("padding bits of result not zero");

  // An empty result stage must never back-pressure the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

bind cpu_8bit_alu_with_flags_top cpualu_checker u_cpualu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/alu_result_checker.sv =====
module alu_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,  // acc[7:0], operand[15:8], flags_in[19:16], zero[23:20]
  input  logic [5:0]  s_tuser,  // mode[2:0], sel[5:3]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,  // result[7:0], flags_out[11:8], zero[15:12]
  input  logic        m_tuser,  // writes_result
  output int          mismatches,
  output int          outstanding
);

  cpualu_pkg::out_item_t awaited_results[$];
  cpualu_pkg::out_item_t want;
  cpualu_pkg::out_item_t got;
  cpualu_pkg::in_item_t  taken_op;

  function automatic void rotate_bits(input logic [2:0] kind, input logic [7:0] v,
                                      input logic cin, output logic [7:0] r,
                                      output logic cout);
    case (kind)
      cpualu_pkg::SHF_RLC: begin
        cout = v[7];
        r = {v[6:0], v[7]};
      end
      cpualu_pkg::SHF_RRC: begin
        cout = v[0];
        r = {v[0], v[7:1]};
      end
      cpualu_pkg::SHF_RL: begin
        cout = v[7];
        r = {v[6:0], cin};
      end
      cpualu_pkg::SHF_RR: begin
        cout = v[0];
        r = {cin, v[7:1]};
      end
      cpualu_pkg::SHF_SLA: begin
        cout = v[7];
        r = {v[6:0], 1'b0};
      end
      cpualu_pkg::SHF_SRA: begin
        cout = v[0];
        r = {v[7], v[7:1]};
      end
      cpualu_pkg::SHF_SWAP: begin
        cout = 1'b0;
        r = {v[3:0], v[7:4]};
      end
      default: begin
        cout = v[0];
        r = {1'b0, v[7:1]};
      end
    endcase
  endfunction

  function automatic cpualu_pkg::out_item_t alu_compute(cpualu_pkg::in_item_t x);
    logic [8:0] wide;
    logic [4:0] nib;
    logic [7:0] r;
    logic [3:0] f;
    logic       c;
    logic       t;
    cpualu_pkg::out_item_t o;
    f = x.flags_in;
    o.result = x.acc;
    o.writes_result = 1'b1;
    o.flags_out = f;
    case (x.mode)
      cpualu_pkg::MODE_ALU: begin
        case (x.sel)
          cpualu_pkg::ALU_ADD, cpualu_pkg::ALU_ADC: begin
            t = (x.sel == cpualu_pkg::ALU_ADC) ? f[cpualu_pkg::FlagC] : 1'b0;
            wide = {1'b0, x.acc} + {1'b0, x.operand} + 9'(t);
            nib = {1'b0, x.acc[3:0]} + {1'b0, x.operand[3:0]} + 5'(t);
            o.result = wide[7:0];
            o.flags_out = '0;
            o.flags_out[cpualu_pkg::FlagZ] = (wide[7:0] == 8'h00);
            o.flags_out[cpualu_pkg::FlagH] = nib[4];
            o.flags_out[cpualu_pkg::FlagC] = wide[8];
          end
          cpualu_pkg::ALU_SUB, cpualu_pkg::ALU_SBC, cpualu_pkg::ALU_CP: begin
            t = (x.sel == cpualu_pkg::ALU_SBC) ? f[cpualu_pkg::FlagC] : 1'b0;
            // bit 8 and bit 4 go high exactly when the difference borrows
            wide = {1'b0, x.acc} - {1'b0, x.operand} - 9'(t);
            nib = {1'b0, x.acc[3:0]} - {1'b0, x.operand[3:0]} - 5'(t);
            o.result = wide[7:0];
            o.writes_result = (x.sel != cpualu_pkg::ALU_CP);
            o.flags_out = '0;
            o.flags_out[cpualu_pkg::FlagZ] = (wide[7:0] == 8'h00);
            o.flags_out[cpualu_pkg::FlagN] = 1'b1;
            o.flags_out[cpualu_pkg::FlagH] = nib[4];
            o.flags_out[cpualu_pkg::FlagC] = wide[8];
          end
          cpualu_pkg::ALU_AND: begin
            o.result = x.acc & x.operand;
            o.flags_out = '0;
            o.flags_out[cpualu_pkg::FlagZ] = (o.result == 8'h00);
            o.flags_out[cpualu_pkg::FlagH] = 1'b1;
          end
          cpualu_pkg::ALU_XOR: begin
            o.result = x.acc ^ x.operand;
            o.flags_out = '0;
            o.flags_out[cpualu_pkg::FlagZ] = (o.result == 8'h00);
          end
          default: begin
            o.result = x.acc | x.operand;
            o.flags_out = '0;
            o.flags_out[cpualu_pkg::FlagZ] = (o.result == 8'h00);
          end
        endcase
      end
      cpualu_pkg::MODE_SHF: begin
        rotate_bits(x.sel, x.operand, f[cpualu_pkg::FlagC], r, c);
        o.result = r;
        o.flags_out = '0;
        o.flags_out[cpualu_pkg::FlagZ] = (r == 8'h00);
        o.flags_out[cpualu_pkg::FlagC] = c;
      end
      cpualu_pkg::MODE_BIT: begin
        o.result = x.operand;
        o.writes_result = 1'b0;
        o.flags_out[cpualu_pkg::FlagZ] = ~x.operand[x.sel];
        o.flags_out[cpualu_pkg::FlagN] = 1'b0;
        o.flags_out[cpualu_pkg::FlagH] = 1'b1;
      end
      cpualu_pkg::MODE_RES: o.result = x.operand & ~(8'd1 << x.sel);
      cpualu_pkg::MODE_SET: o.result = x.operand | (8'd1 << x.sel);
      cpualu_pkg::MODE_MISC: begin
        case (x.sel)
          cpualu_pkg::MISC_RLCA, cpualu_pkg::MISC_RRCA,
          cpualu_pkg::MISC_RLA, cpualu_pkg::MISC_RRA: begin
            rotate_bits(x.sel, x.acc, f[cpualu_pkg::FlagC], r, c);
            o.result = r;
            o.flags_out = '0;
            o.flags_out[cpualu_pkg::FlagC] = c;
          end
          cpualu_pkg::MISC_DAA: begin
            r = x.acc;
            c = f[cpualu_pkg::FlagC];
            if (!f[cpualu_pkg::FlagN]) begin
              if (c || r > cpualu_pkg::DaaUpperLimit) begin
                r = r + cpualu_pkg::DaaUpperAdj;
                c = 1'b1;
              end
              if (f[cpualu_pkg::FlagH] || r[3:0] > cpualu_pkg::DaaLowerLimit)
                r = r + cpualu_pkg::DaaLowerAdj;
            end else begin
              if (c) r = r - cpualu_pkg::DaaUpperAdj;
              if (f[cpualu_pkg::FlagH]) r = r - cpualu_pkg::DaaLowerAdj;
            end
            o.result = r;
            o.flags_out = '0;
            o.flags_out[cpualu_pkg::FlagZ] = (r == 8'h00);
            o.flags_out[cpualu_pkg::FlagN] = f[cpualu_pkg::FlagN];
            o.flags_out[cpualu_pkg::FlagC] = c;
          end
          cpualu_pkg::MISC_CPL: begin
            o.result = ~x.acc;
            o.flags_out[cpualu_pkg::FlagN] = 1'b1;
            o.flags_out[cpualu_pkg::FlagH] = 1'b1;
          end
          cpualu_pkg::MISC_SCF: begin
            o.flags_out[cpualu_pkg::FlagN] = 1'b0;
            o.flags_out[cpualu_pkg::FlagH] = 1'b0;
            o.flags_out[cpualu_pkg::FlagC] = 1'b1;
          end
          default: begin
            o.flags_out[cpualu_pkg::FlagN] = 1'b0;
            o.flags_out[cpualu_pkg::FlagH] = 1'b0;
            o.flags_out[cpualu_pkg::FlagC] = ~f[cpualu_pkg::FlagC];
          end
        endcase
      end
      default: o.writes_result = 1'b0;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      awaited_results.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      // pop before push so a result never meets the transaction of its own cycle
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transaction: result %02h", m_tdata[7:0]);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          got.result = m_tdata[7:0];
          got.flags_out = m_tdata[11:8];
          got.writes_result = m_tuser;
          if (got.result !== want.result) begin
            $error("result: expected %02h, got %02h", want.result, got.result);
            mismatches++;
          end
          if (got.writes_result !== want.writes_result) begin
            $error("writes_result: expected %0b, got %0b", want.writes_result,
                   got.writes_result);
            mismatches++;
          end
          if (got.flags_out !== want.flags_out) begin
            $error("flags_out: expected %04b, got %04b", want.flags_out, got.flags_out);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        taken_op.acc = s_tdata[7:0];
        taken_op.operand = s_tdata[15:8];
        taken_op.flags_in = s_tdata[19:16];
        taken_op.mode = s_tuser[2:0];
        taken_op.sel = s_tuser[5:3];
        awaited_results.push_back(alu_compute(taken_op));
      end
      outstanding <= awaited_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;

  localparam int StallLimit = 2000;
  localparam int LongHold = 200;
  localparam int RandomOps = 1680;
  localparam logic [2:0] ModeSpareLo = 3'd6;
  localparam logic [2:0] ModeSpareHi = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic [5:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  logic        m_tuser;

  int mismatches;
  int outstanding;
  int stall_cycles = 0;
  bit quiet_tail = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cpu_8bit_alu_with_flags_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  alu_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic cpualu_pkg::in_item_t make_op(logic [2:0] mode, logic [2:0] sel,
                                                   logic [7:0] acc, logic [7:0] opnd,
                                                   logic [3:0] flags);
    cpualu_pkg::in_item_t x;
    x.mode = mode;
    x.sel = sel;
    x.acc = acc;
    x.operand = opnd;
    x.flags_in = flags;
    return x;
  endfunction

  function automatic logic [7:0] random_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 8'h00;
        1: v = 8'hFF;
        2: v = 8'h0F;
        3: v = 8'hF0;
        4: v = 8'h80;
        5: v = 8'h01;
        6: v = 8'h99;
        default: v = 8'h9A;
      endcase
    end
    return v;
  endfunction

  function automatic cpualu_pkg::in_item_t random_op();
    cpualu_pkg::in_item_t x;
    if ($urandom_range(0, 99) < 2)
      x.mode = ($urandom_range(0, 1) == 0) ? ModeSpareLo : ModeSpareHi;
    else
      x.mode = 3'($urandom_range(cpualu_pkg::MODE_ALU, cpualu_pkg::MODE_MISC));
    x.sel = 3'($urandom_range(0, 7));
    x.acc = random_byte();
    x.operand = random_byte();
    x.flags_in = 4'($urandom_range(0, 15));
    return x;
  endfunction

  // offer one transaction and hold it until the block takes it
  task automatic offer(cpualu_pkg::in_item_t x);
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, x.flags_in, x.operand, x.acc};
    s_tuser <= {x.sel, x.mode};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, quiet_tail ? 1 : 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // carries out of both nibbles, borrows, zero results
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_ADD, 8'hFF, 8'h01, 4'h0));
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_ADC, 8'h0F, 8'h00, 4'hF));
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_SUB, 8'h10, 8'h01, 4'h0));
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_SBC, 8'h00, 8'h00, 4'hF));
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_AND, 8'hFF, 8'h00, 4'hF));
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_XOR, 8'hA5, 8'hA5, 4'h0));
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_OR, 8'h00, 8'h00, 4'hF));
    offer(make_op(cpualu_pkg::MODE_ALU, cpualu_pkg::ALU_CP, 8'h3C, 8'h3C, 4'h0));
    for (int s = 0; s < 8; s++)
      offer(make_op(cpualu_pkg::MODE_SHF, 3'(s), 8'h00, 8'h81, 4'hF));
    offer(make_op(cpualu_pkg::MODE_BIT, 3'd7, 8'h00, 8'h7F, 4'h0));
    offer(make_op(cpualu_pkg::MODE_RES, 3'd0, 8'h00, 8'hFF, 4'hF));
    offer(make_op(cpualu_pkg::MODE_SET, 3'd7, 8'h00, 8'h00, 4'h0));
    // all accumulator ops, among them decimal adjust after subtraction with both adjusts
    for (int s = 0; s < 8; s++)
      offer(make_op(cpualu_pkg::MODE_MISC, 3'(s), 8'h81, 8'h00, 4'hF));
    // decimal adjust after addition that wraps to zero with carry
    offer(make_op(cpualu_pkg::MODE_MISC, cpualu_pkg::MISC_DAA, 8'h9A, 8'h00, 4'h0));
    offer(make_op(ModeSpareLo, 3'd0, 8'h5A, 8'hA5, 4'hA));
    offer(make_op(ModeSpareHi, 3'd7, 8'hC3, 8'h3C, 4'h5));

    // keep offering while the receiver holds off, so the block backs up
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) offer(random_op());
    drain();

    for (int sent = 0; sent < RandomOps; sent++) begin
      if (sent == 700) drain();
      if (sent == 1400) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 13));
      offer(random_op());
    end
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
